[hw/rtl/shsat_pkg.sv]
// Package for the stepper half-step angle tracker.
// Holds the operation codes, the motor state type and the half-step coil tables.
// No dependencies.
`default_nettype none

package shsat_pkg;

    localparam int unsigned ANGLE_W  = 16;
    localparam int unsigned TARGET_W = 17;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned COILS_W  = 4;

    localparam logic [ANGLE_W-1:0]  STEP_ANGLE      = 16'd9;
    localparam logic [ANGLE_W-1:0]  FULL_TURN_LESS  = 16'd35991;
    localparam logic [TARGET_W-1:0] STEP_REMAIN     = 17'd9;
    localparam logic [COILS_W-1:0]  COIL_A          = 4'd1;

    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_MOVE   = 2'd2,
        OP_ZERO   = 2'd3
    } t_op;

    typedef struct packed {
        logic                run_enable;
        logic [PHASE_W-1:0]  phase;
        logic [ANGLE_W-1:0]  shaft_angle;
        logic [TARGET_W-1:0] remaining;
        logic                target_mode;
        logic [COILS_W-1:0]  coil_state;
    } t_state;

    function automatic logic [COILS_W-1:0] fwd_coils(input logic [PHASE_W-1:0] p);
        logic [COILS_W-1:0] c;
        case (p)
            3'd0: c = 4'd1;
            3'd1: c = 4'd3;
            3'd2: c = 4'd2;
            3'd3: c = 4'd6;
            3'd4: c = 4'd4;
            3'd5: c = 4'd12;
            3'd6: c = 4'd8;
            3'd7: c = 4'd9;
            default: c = 4'd1;
        endcase
        return c;
    endfunction

    function automatic logic [COILS_W-1:0] rev_coils(input logic [PHASE_W-1:0] p);
        logic [COILS_W-1:0] c;
        case (p)
            3'd0: c = 4'd1;
            3'd1: c = 4'd9;
            3'd2: c = 4'd8;
            3'd3: c = 4'd12;
            3'd4: c = 4'd4;
            3'd5: c = 4'd6;
            3'd6: c = 4'd2;
            3'd7: c = 4'd3;
            default: c = 4'd1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/shsat_next_state.sv]
// Next-state logic of the stepper half-step angle tracker.
// Computes the state after one request and the target-reached flag; uses shsat_pkg.
`default_nettype none

module shsat_next_state (
    input  wire shsat_pkg::t_state                      i_state,
    input  wire logic [1:0]                             i_operation,
    input  wire logic [shsat_pkg::TARGET_W-1:0]         i_target_angle,
    input  wire logic                                   i_reverse_direction,
    output shsat_pkg::t_state                           o_state,
    output logic                                        o_target_reached
);

    shsat_pkg::t_state        stepped;
    logic [shsat_pkg::ANGLE_W-1:0] angle_fwd;

    always_comb begin
        stepped   = i_state;
        angle_fwd = i_state.shaft_angle + shsat_pkg::STEP_ANGLE;
        if (i_reverse_direction) begin
            stepped.coil_state = shsat_pkg::rev_coils(i_state.phase);
            if (i_state.shaft_angle >= shsat_pkg::STEP_ANGLE) begin
                stepped.shaft_angle = i_state.shaft_angle - shsat_pkg::STEP_ANGLE;
            end else begin
                stepped.shaft_angle = i_state.shaft_angle + shsat_pkg::FULL_TURN_LESS;
            end
        end else begin
            stepped.coil_state = shsat_pkg::fwd_coils(i_state.phase);
            if (i_state.shaft_angle >= shsat_pkg::FULL_TURN_LESS) begin
                stepped.shaft_angle = i_state.shaft_angle - shsat_pkg::FULL_TURN_LESS;
            end else begin
                stepped.shaft_angle = angle_fwd;
            end
        end
        stepped.phase = i_state.phase + 3'd1;
    end

    always_comb begin
        o_state          = i_state;
        o_target_reached = 1'b0;
        case (shsat_pkg::t_op'(i_operation))
            shsat_pkg::OP_STEP: begin
                if (i_state.run_enable) begin
                    if (i_state.target_mode &&
                        i_state.remaining <= shsat_pkg::STEP_REMAIN) begin
                        // The move ends here; a step is taken only if something remained.
                        if (i_state.remaining != '0) begin
                            o_state.phase       = stepped.phase;
                            o_state.shaft_angle = stepped.shaft_angle;
                        end
                        o_state.remaining   = '0;
                        o_state.target_mode = 1'b0;
                        o_state.run_enable  = 1'b0;
                        o_state.coil_state  = shsat_pkg::COIL_A;
                        o_target_reached    = 1'b1;
                    end else begin
                        o_state = stepped;
                        if (i_state.target_mode) begin
                            o_state.remaining = i_state.remaining - shsat_pkg::STEP_REMAIN;
                        end
                    end
                end
            end
            shsat_pkg::OP_TOGGLE: begin
                o_state.run_enable = ~i_state.run_enable;
                o_state.phase      = '0;
                o_state.coil_state = shsat_pkg::COIL_A;
            end
            shsat_pkg::OP_MOVE: begin
                o_state.remaining   = i_target_angle;
                o_state.target_mode = 1'b1;
                o_state.run_enable  = 1'b1;
            end
            shsat_pkg::OP_ZERO: begin
                o_state.shaft_angle = '0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/stepper_half_step_angle_tracker.sv]
// Top level of the stepper half-step angle tracker.
// Input register, next-state logic (shsat_next_state) and result register; uses shsat_pkg.
//
// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_ready      i_operation, i_target_angle
// result    out        o_out_valid / i_out_ready    o_coils, o_angle, o_running,
//                                                   o_target_reached
// config    in         i_cfg_we                     i_cfg_data
//
// One request is taken per cycle while the result is not stalled; its result is valid once it
// has passed the input register and been written into the result register.
// The request passes an input register, then the next-state logic, whose result is the
// motor state register itself, shown on the result ports.
// Reset is synchronous and active low; it clears both valid flags and the motor state.
// A stalled result holds the state; an empty input register still takes one request,
// and further requests wait.
`default_nettype none

module stepper_half_step_angle_tracker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_operation,
    input  wire logic [shsat_pkg::TARGET_W-1:0]      i_target_angle,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [shsat_pkg::COILS_W-1:0]            o_coils,
    output logic [shsat_pkg::ANGLE_W-1:0]            o_angle,
    output logic                                     o_running,
    output logic                                     o_target_reached,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_data
);

    logic                               r_in_valid;
    logic [1:0]                         r_operation;
    logic [shsat_pkg::TARGET_W-1:0]     r_target_angle;
    logic                               r_reverse_direction;
    shsat_pkg::t_state                  r_state;
    shsat_pkg::t_state                  n_state;
    logic                               r_target_reached;
    logic                               n_target_reached;
    logic                               r_out_valid;
    logic                               advance;

    assign advance    = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_in_valid | advance;

    shsat_next_state u_next_state (
        .i_state             (r_state),
        .i_operation         (r_operation),
        .i_target_angle      (r_target_angle),
        .i_reverse_direction (r_reverse_direction),
        .o_state             (n_state),
        .o_target_reached    (n_target_reached)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_reverse_direction <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_operation    <= i_operation;
            r_target_angle <= i_target_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_target_reached <= 1'b0;
            r_state.run_enable  <= 1'b0;
            r_state.phase       <= '0;
            r_state.shaft_angle <= '0;
            r_state.remaining   <= '0;
            r_state.target_mode <= 1'b0;
            r_state.coil_state  <= shsat_pkg::COIL_A;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state          <= n_state;
                r_target_reached <= n_target_reached;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coils          = r_state.coil_state;
    assign o_angle          = r_state.shaft_angle;
    assign o_running        = r_state.run_enable;
    assign o_target_reached = r_target_reached;

endmodule

`default_nettype wire
